### design/psl_pkg.sv
// ----------------------------------------------------------------------------
// psl_pkg
// shared types, token kinds, character codes and lookups for the lexer
// ----------------------------------------------------------------------------
`default_nettype none

package psl_pkg;

  localparam int FIELD_W = 16;
  localparam int KIND_W  = 5;
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = 2;
  localparam int QCNT_W  = 3;

  typedef enum logic [2:0] {
    MODE_NORMAL  = 3'd0,
    MODE_OP      = 3'd1,
    MODE_SLASH   = 3'd2,
    MODE_COMMENT = 3'd3,
    MODE_STRING  = 3'd4
  } scan_mode_t;

  localparam logic [KIND_W-1:0] KIND_OP_BASE = 5'd10;
  localparam logic [KIND_W-1:0] KIND_SLASH   = 5'd18;
  localparam logic [KIND_W-1:0] KIND_STRING  = 5'd19;
  localparam logic [KIND_W-1:0] KIND_EOF     = 5'd20;
  localparam logic [KIND_W-1:0] KIND_UNTERM  = 5'd21;

  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_NL    = 8'h0a;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [FIELD_W-1:0] start;
    logic [FIELD_W-1:0] len;
    logic [FIELD_W-1:0] line;
    logic               last;
  } tok_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] idx;
  } punct_t;

  typedef struct packed {
    logic       hit;
    logic [1:0] idx;
  } opch_t;

  function automatic punct_t punct_lookup(input logic [7:0] c);
    punct_t r;
    r.hit = 1'b1;
    r.idx = 4'd0;
    case (c)
      8'h28: r.idx = 4'd0;
      8'h29: r.idx = 4'd1;
      8'h7b: r.idx = 4'd2;
      8'h7d: r.idx = 4'd3;
      8'h2c: r.idx = 4'd4;
      8'h2e: r.idx = 4'd5;
      8'h2d: r.idx = 4'd6;
      8'h2b: r.idx = 4'd7;
      8'h3b: r.idx = 4'd8;
      8'h2a: r.idx = 4'd9;
      default: r.hit = 1'b0;
    endcase
    return r;
  endfunction

  function automatic opch_t op_lookup(input logic [7:0] c);
    opch_t r;
    r.hit = 1'b1;
    r.idx = 2'd0;
    case (c)
      8'h21: r.idx = 2'd0;
      8'h3d: r.idx = 2'd1;
      8'h3c: r.idx = 2'd2;
      8'h3e: r.idx = 2'd3;
      default: r.hit = 1'b0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

### design/psl_scan_core.sv
// ----------------------------------------------------------------------------
// psl_scan_core
// scanner state and one-pass token decode for one source item
// ----------------------------------------------------------------------------
`default_nettype none

module psl_scan_core import psl_pkg::*; #(
  parameter int OFFSET_WIDTH = 16,
  parameter int LINE_WIDTH   = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       fire,
  input  wire logic [7:0] char_byte,
  input  wire logic       end_of_source,
  output tok_t            tok0,
  output tok_t            tok1,
  output logic [1:0]      wr_n
);

  scan_mode_t              mode_r, mode_nxt;
  logic [1:0]              pend_r, pend_nxt;
  logic [OFFSET_WIDTH-1:0] pos_r, pos_nxt;
  logic [OFFSET_WIDTH-1:0] tb_r, tb_nxt;
  logic [LINE_WIDTH-1:0]   line_r, line_nxt;

  logic [LINE_WIDTH-1:0]   line_inc;
  logic [OFFSET_WIDTH-1:0] len_str, len_unterm;
  logic [FIELD_W-1:0]      pos16, tb16, line16, len_str16, len_unterm16;
  logic [OFFSET_WIDTH+FIELD_W-1:0] pos_ext, tb_ext, str_ext, unt_ext;
  logic [LINE_WIDTH+FIELD_W-1:0]   line_ext;
  logic [KIND_W-1:0]       op_kind;
  punct_t                  pk;
  opch_t                   oc;

  tok_t e0, e1;
  logic e0_v, e1_v, do_normal;

  assign line_inc     = (&line_r) ? line_r : line_r + LINE_WIDTH'(1);
  assign len_str      = pos_r + OFFSET_WIDTH'(1) - tb_r;
  assign len_unterm   = pos_r - tb_r;
  assign pos_ext      = {{FIELD_W{1'b0}}, pos_r};
  assign tb_ext       = {{FIELD_W{1'b0}}, tb_r};
  assign str_ext      = {{FIELD_W{1'b0}}, len_str};
  assign unt_ext      = {{FIELD_W{1'b0}}, len_unterm};
  assign line_ext     = {{FIELD_W{1'b0}}, line_r};
  assign pos16        = pos_ext[FIELD_W-1:0];
  assign tb16         = tb_ext[FIELD_W-1:0];
  assign len_str16    = str_ext[FIELD_W-1:0];
  assign len_unterm16 = unt_ext[FIELD_W-1:0];
  assign line16       = line_ext[FIELD_W-1:0];
  assign op_kind      = KIND_OP_BASE + {2'b00, pend_r, 1'b0};
  assign pk           = punct_lookup(char_byte);
  assign oc           = op_lookup(char_byte);

  // byte is scanned afresh from normal mode
  always_comb begin
    do_normal = 1'b0;
    if (!end_of_source) begin
      case (mode_r)
        MODE_OP:      do_normal = (char_byte != CH_EQ);
        MODE_SLASH:   do_normal = (char_byte != CH_SLASH);
        MODE_COMMENT: do_normal = 1'b0;
        MODE_STRING:  do_normal = 1'b0;
        default:      do_normal = 1'b1;
      endcase
    end
  end

  // next state
  always_comb begin
    mode_nxt = mode_r;
    pend_nxt = pend_r;
    pos_nxt  = pos_r;
    tb_nxt   = tb_r;
    line_nxt = line_r;
    if (end_of_source) begin
      mode_nxt = MODE_NORMAL;
      pend_nxt = '0;
      pos_nxt  = '0;
      tb_nxt   = '0;
      line_nxt = LINE_WIDTH'(1);
    end else begin
      pos_nxt = pos_r + OFFSET_WIDTH'(1);
      case (mode_r)
        MODE_OP: begin
          if (char_byte == CH_EQ) begin
            mode_nxt = MODE_NORMAL;
          end
        end
        MODE_SLASH: begin
          if (char_byte == CH_SLASH) begin
            mode_nxt = MODE_COMMENT;
          end
        end
        MODE_COMMENT: begin
          if (char_byte == CH_NL) begin
            line_nxt = line_inc;
            mode_nxt = MODE_NORMAL;
          end
        end
        MODE_STRING: begin
          if (char_byte == CH_NL) begin
            line_nxt = line_inc;
          end else if (char_byte == CH_QUOTE) begin
            mode_nxt = MODE_NORMAL;
          end
        end
        default: mode_nxt = mode_r;
      endcase
      if (do_normal) begin
        tb_nxt   = pos_r;
        mode_nxt = MODE_NORMAL;
        if (pk.hit) begin
          mode_nxt = MODE_NORMAL;
        end else if (oc.hit) begin
          mode_nxt = MODE_OP;
          pend_nxt = oc.idx;
        end else if (char_byte == CH_SLASH) begin
          mode_nxt = MODE_SLASH;
        end else if (char_byte == CH_QUOTE) begin
          mode_nxt = MODE_STRING;
        end else if (char_byte == CH_NL) begin
          line_nxt = line_inc;
        end
      end
    end
  end

  // emitted tokens
  always_comb begin
    e0_v = 1'b0;
    e1_v = 1'b0;
    e0   = '{kind: op_kind, start: tb16, len: FIELD_W'(1), line: line16, last: 1'b0};
    e1   = '{kind: KIND_EOF, start: pos16, len: '0, line: line16, last: 1'b0};
    if (end_of_source) begin
      case (mode_r)
        MODE_OP: e0_v = 1'b1;
        MODE_SLASH: begin
          e0_v    = 1'b1;
          e0.kind = KIND_SLASH;
        end
        MODE_STRING: begin
          e0_v    = 1'b1;
          e0.kind = KIND_UNTERM;
          e0.len  = len_unterm16;
        end
        default: e0_v = 1'b0;
      endcase
      e1_v = 1'b1;
    end else begin
      case (mode_r)
        MODE_OP: begin
          e0_v = 1'b1;
          if (char_byte == CH_EQ) begin
            e0.kind = op_kind + KIND_W'(1);
            e0.len  = FIELD_W'(2);
          end
        end
        MODE_SLASH: begin
          if (char_byte != CH_SLASH) begin
            e0_v    = 1'b1;
            e0.kind = KIND_SLASH;
          end
        end
        MODE_STRING: begin
          if (char_byte == CH_QUOTE) begin
            e0_v    = 1'b1;
            e0.kind = KIND_STRING;
            e0.len  = len_str16;
          end
        end
        default: e0_v = 1'b0;
      endcase
      if (do_normal) begin
        e1.start = pos16;
        e1.len   = FIELD_W'(1);
        e1.kind  = {1'b0, pk.idx};
        e1_v     = pk.hit;
      end
    end
  end

  // pack emitted tokens into consecutive slots, mark the final one
  always_comb begin
    tok0 = e0;
    tok1 = e1;
    wr_n = 2'd0;
    if (!fire) begin
      wr_n = 2'd0;
    end else if (e0_v && e1_v) begin
      wr_n      = 2'd2;
      tok1.last = 1'b1;
    end else if (e0_v) begin
      wr_n      = 2'd1;
      tok0.last = 1'b1;
    end else if (e1_v) begin
      wr_n      = 2'd1;
      tok0      = e1;
      tok0.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NORMAL;
      pend_r <= '0;
      pos_r  <= '0;
      tb_r   <= '0;
      line_r <= LINE_WIDTH'(1);
    end else if (fire) begin
      mode_r <= mode_nxt;
      pend_r <= pend_nxt;
      pos_r  <= pos_nxt;
      tb_r   <= tb_nxt;
      line_r <= line_nxt;
    end
  end

  a_eos_ends_with_eof: assert property (@(posedge clk) disable iff (!rst_n)
    fire && end_of_source |->
      (wr_n == 2'd1 && tok0.kind == KIND_EOF) || (wr_n == 2'd2 && tok1.kind == KIND_EOF))
    else $error("end of source did not end with eof token");

  a_eos_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    fire && end_of_source |=> mode_r == MODE_NORMAL && pos_r == '0 && line_r == LINE_WIDTH'(1))
    else $error("scanner state not restarted after end of source");

  a_pos_holds_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(pos_r) && $stable(line_r))
    else $error("scanner state moved without an item");

  a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    line_r != '0)
    else $error("line count reached zero");

endmodule

`default_nettype wire

### design/psl_tok_fifo.sv
// ----------------------------------------------------------------------------
// psl_tok_fifo
// four-entry token queue, takes up to two tokens a cycle, drives one out
// ----------------------------------------------------------------------------
`default_nettype none

module psl_tok_fifo import psl_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic [1:0] wr_n,
  input  wire tok_t       wr0,
  input  wire tok_t       wr1,
  output logic            room2,
  output logic            rd_valid,
  input  wire logic       rd_ready,
  output tok_t            rd_data
);

  tok_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] head_r, head_nxt;
  logic [QPTR_W-1:0] tail_r, tail_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic [QPTR_W-1:0] tail_p1;
  logic              pop;

  assign tail_p1  = tail_r + QPTR_W'(1);
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[head_r];
  assign pop      = rd_valid && rd_ready;
  assign room2    = (cnt_r <= QCNT_W'(QDEPTH - 2));
  assign head_nxt = head_r + QPTR_W'(pop);
  assign tail_nxt = tail_r + QPTR_W'(wr_n);
  assign cnt_nxt  = cnt_r + QCNT_W'(wr_n) - QCNT_W'(pop);

  always_ff @(posedge clk) begin
    if (wr_n != 2'd0) begin
      mem_r[tail_r] <= wr0;
    end
    if (wr_n == 2'd2) begin
      mem_r[tail_p1] <= wr1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QDEPTH))
    else $error("token queue overflow");

  a_write_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    wr_n != 2'd0 |-> room2)
    else $error("token written without room");

  a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    wr_n == 2'd0 && !pop |=> $stable(cnt_r) && $stable(tail_r))
    else $error("queue count changed without traffic");

endmodule

`default_nettype wire

### design/punctuation_string_lexer_unit.sv
// ----------------------------------------------------------------------------
// punctuation_string_lexer_unit
// byte-stream lexer for punctuators, compare operators, slash and strings
// ----------------------------------------------------------------------------
// path: an item taken at the input is held in the input register, then its tokens
//   are written to the token queue that drives out_tvalid
// throughput: one item per cycle while the queue has room for two tokens; an item
//   giving two tokens uses the single output port twice, paced by the four-entry token queue
// reset: rst_n synchronous active low; empties the queue, line count to one,
//   offsets to zero, scanner back to normal mode
`default_nettype none

module punctuation_string_lexer_unit import psl_pkg::*; #(
  parameter int OFFSET_WIDTH = 16,
  parameter int LINE_WIDTH   = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // char_byte
  input  wire logic        in_tuser,   // end_of_source
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [55:0]      out_tdata,  // token_kind, lexeme_start, lexeme_length, line_number
  output logic             out_tlast
);

  logic       in_valid_r;
  logic [7:0] char_r;
  logic       eos_r;
  logic       fire, room2;
  logic [1:0] wr_n;
  tok_t       tok0, tok1, head;

  assign fire      = in_valid_r && room2;
  assign in_tready = !in_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      char_r <= in_tdata;
      eos_r  <= in_tuser;
    end
  end

  psl_scan_core #(
    .OFFSET_WIDTH (OFFSET_WIDTH),
    .LINE_WIDTH   (LINE_WIDTH)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .fire          (fire),
    .char_byte     (char_r),
    .end_of_source (eos_r),
    .tok0          (tok0),
    .tok1          (tok1),
    .wr_n          (wr_n)
  );

  psl_tok_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_n     (wr_n),
    .wr0      (tok0),
    .wr1      (tok1),
    .room2    (room2),
    .rd_valid (out_tvalid),
    .rd_ready (out_tready),
    .rd_data  (head)
  );

  assign out_tdata = {3'b000, head.line, head.len, head.start, head.kind};
  assign out_tlast = head.last;

endmodule

`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the punctuation and string lexer: source texts are
// streamed in byte by byte, an in-bench scanner works out the tokens each item
// should give, and every token leaving the block is checked against them
// ----------------------------------------------------------------------------

module tb_top;
  import psl_pkg::*;

  localparam int LIMIT = 1000000;
  localparam int RANDOM_ITEMS = 1850;
  localparam int CHOKE_CYCLES = 400;

  typedef struct {
    logic [7:0] ch;
    logic       eos;
    int         gap;
    bit         choke;
    bit         drain;
  } src_item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic        out_tlast;

  punctuation_string_lexer_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  // source side
  src_item_t src_q[$];
  src_item_t cur;
  bit        quiet = 1'b0;
  bit        next_choke = 1'b0;
  bit        next_drain = 1'b0;
  bit        mid_drained = 1'b0;
  bit        fill_done = 1'b0;
  bit        stim_done = 1'b0;
  int        gap_left = 0;
  int        choke_cnt = 0;
  int        choke_seen = 0;
  int        hold_left = 0;
  int        cycles = 0;
  int        n_accepted = 0;
  int        n_texts = 0;
  int        n_checked = 0;
  int        errors = 0;
  int        random_items = 0;

  // scanner state
  scan_mode_t  lx_mode;
  logic [1:0]  lx_op;
  logic [15:0] lx_pos;
  logic [15:0] lx_begin;
  logic [15:0] lx_line;
  tok_t        run_q[$];
  tok_t        token_q[$];
  string       punct_set = "(){},.-+;*";
  string       op_set = "!=<>";

  function automatic void reset_lexer();
    lx_mode = MODE_NORMAL;
    lx_op = 2'd0;
    lx_pos = 16'd0;
    lx_begin = 16'd0;
    lx_line = 16'd1;
  endfunction

  function automatic void emit_tok(input logic [4:0] k, input logic [15:0] s,
                                   input logic [15:0] n);
    tok_t t;
    t.kind = k;
    t.start = s;
    t.len = n;
    t.line = lx_line;
    t.last = 1'b0;
    run_q = {run_q, t};
  endfunction

  function automatic void count_line();
    if (lx_line != 16'hffff) lx_line = lx_line + 16'd1;
  endfunction

  function automatic int char_index(input string set, input logic [7:0] c);
    for (int i = 0; i < set.len(); i++) begin
      if (set[i] == c) return i;
    end
    return -1;
  endfunction

  function automatic logic [4:0] op_kind(input logic [1:0] op, input logic pair);
    return KIND_OP_BASE + {2'b00, op, pair};
  endfunction

  function automatic void scan_plain(input logic [7:0] c);
    int p;
    int q;
    lx_begin = lx_pos;
    lx_mode = MODE_NORMAL;
    p = char_index(punct_set, c);
    q = char_index(op_set, c);
    if (p >= 0) begin
      emit_tok(p[4:0], lx_begin, 16'd1);
    end else if (q >= 0) begin
      lx_mode = MODE_OP;
      lx_op = q[1:0];
    end else if (c == CH_SLASH) begin
      lx_mode = MODE_SLASH;
    end else if (c == CH_QUOTE) begin
      lx_mode = MODE_STRING;
    end else if (c == CH_NL) begin
      count_line();
    end
  endfunction

  function automatic void lex_item(input logic [7:0] c, input logic eos);
    tok_t t;
    run_q.delete();
    if (eos) begin
      case (lx_mode)
        MODE_OP:     emit_tok(op_kind(lx_op, 1'b0), lx_begin, 16'd1);
        MODE_SLASH:  emit_tok(KIND_SLASH, lx_begin, 16'd1);
        MODE_STRING: emit_tok(KIND_UNTERM, lx_begin, lx_pos - lx_begin);
        default: ;
      endcase
      emit_tok(KIND_EOF, lx_pos, 16'd0);
      reset_lexer();
    end else begin
      case (lx_mode)
        MODE_OP: begin
          if (c == CH_EQ) begin
            emit_tok(op_kind(lx_op, 1'b1), lx_begin, 16'd2);
            lx_mode = MODE_NORMAL;
          end else begin
            emit_tok(op_kind(lx_op, 1'b0), lx_begin, 16'd1);
            scan_plain(c);
          end
        end
        MODE_SLASH: begin
          if (c == CH_SLASH) begin
            lx_mode = MODE_COMMENT;
          end else begin
            emit_tok(KIND_SLASH, lx_begin, 16'd1);
            scan_plain(c);
          end
        end
        MODE_COMMENT: begin
          if (c == CH_NL) begin
            count_line();
            lx_mode = MODE_NORMAL;
          end
        end
        MODE_STRING: begin
          if (c == CH_NL) begin
            count_line();
          end else if (c == CH_QUOTE) begin
            emit_tok(KIND_STRING, lx_begin, lx_pos + 16'd1 - lx_begin);
            lx_mode = MODE_NORMAL;
          end
        end
        default: scan_plain(c);
      endcase
      lx_pos = lx_pos + 16'd1;
    end
    for (int i = 0; i < run_q.size(); i++) begin
      t = run_q[i];
      t.last = (i == run_q.size() - 1);
      token_q = {token_q, t};
    end
  endfunction

  // stimulus building
  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic push_item(input logic [7:0] c, input logic e);
    src_item_t it;
    it.ch = c;
    it.eos = e;
    it.gap = quiet ? 0 : draw_gap();
    it.choke = next_choke;
    it.drain = next_drain;
    next_choke = 1'b0;
    next_drain = 1'b0;
    src_q = {src_q, it};
    random_items++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_item(s[i], 1'b0);
  endtask

  task automatic push_eos();
    push_item(8'($urandom_range(0, 255)), 1'b1);
    n_texts++;
  endtask

  task automatic push_fragment();
    int r;
    int n;
    logic [7:0] c;
    r = $urandom_range(0, 99);
    if (r < 25) begin
      push_item(punct_set[$urandom_range(0, 9)], 1'b0);
    end else if (r < 45) begin
      push_item(op_set[$urandom_range(0, 3)], 1'b0);
      if ($urandom_range(0, 1)) begin
        push_item(CH_EQ, 1'b0);
      end
    end else if (r < 52) begin
      push_item(CH_SLASH, 1'b0);
    end else if (r < 60) begin
      push_text("//");
      n = $urandom_range(0, 6);
      for (int i = 0; i < n; i++) begin
        do c = 8'($urandom_range(0, 255)); while (c == CH_NL);
        push_item(c, 1'b0);
      end
      push_item(CH_NL, 1'b0);
    end else if (r < 72) begin
      push_item(CH_QUOTE, 1'b0);
      n = $urandom_range(0, 8);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 7) == 0) c = CH_NL;
        else do c = 8'($urandom_range(0, 255)); while (c == CH_QUOTE);
        push_item(c, 1'b0);
      end
      if ($urandom_range(0, 9) != 0) begin
        push_item(CH_QUOTE, 1'b0);
      end
    end else if (r < 80) begin
      push_item(CH_NL, 1'b0);
    end else if (r < 88) begin
      case ($urandom_range(0, 2))
        0: push_item(8'h20, 1'b0);
        1: push_item(8'h09, 1'b0);
        default: push_item(8'h0d, 1'b0);
      endcase
    end else begin
      push_item(8'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  initial begin : fill_stimulus
    int n;
    quiet = 1'b1;
    // every punctuator, every operator form, pending operator flushed at the end
    push_text("(){},.-+;*!!===<<=>>==");
    push_eos();
    // slash then byte, comment, string across lines, slash flushed at the end
    push_text("/(//x\n\"a\n\"/");
    push_eos();
    // unterminated string, then an empty text
    push_text("\"ab");
    push_eos();
    push_eos();
    // long output stall while the sender keeps going, after a full drain
    next_drain = 1'b1;
    next_choke = 1'b1;
    for (int i = 0; i < 60; i++) push_item(punct_set[$urandom_range(0, 9)], 1'b0);
    push_eos();
    while (random_items < RANDOM_ITEMS) begin
      quiet = ($urandom_range(0, 3) == 0);
      if (!mid_drained && random_items > RANDOM_ITEMS / 2) begin
        next_drain = 1'b1;
        mid_drained = 1'b1;
      end
      n = ($urandom_range(0, 19) == 0) ? 40 : $urandom_range(1, 12);
      for (int i = 0; i < n; i++) push_fragment();
      push_eos();
    end
    fill_done = 1'b1;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
  end

  // source driver
  always @(posedge clk) begin : drive_source
    logic      nv;
    src_item_t hd;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      reset_lexer();
      gap_left = 0;
    end else if (!(in_tvalid && !in_tready)) begin
      nv = 1'b0;
      if (in_tvalid) begin
        lex_item(cur.ch, cur.eos);
        n_accepted++;
        if (cur.choke) choke_cnt <= choke_cnt + 1;
      end
      if (gap_left > 0) begin
        gap_left--;
      end else if (src_q.size() > 0) begin
        hd = src_q[0];
        if (hd.drain && token_q.size() != 0) begin
          nv = 1'b0;
        end else if (hd.gap > 0) begin
          gap_left = hd.gap - 1;
          hd.gap = 0;
          hd.drain = 1'b0;
          src_q[0] = hd;
        end else begin
          void'(src_q.pop_front());
          cur = hd;
          in_tdata <= hd.ch;
          in_tuser <= hd.eos;
          nv = 1'b1;
        end
      end else if (fill_done) begin
        stim_done = 1'b1;
      end
      in_tvalid <= nv;
    end
  end

  // token sink readiness
  always @(posedge clk) begin : drive_sink
    int  nh;
    int  r;
    logic rdy;
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left <= 0;
    end else begin
      nh = hold_left;
      if (choke_cnt != choke_seen) begin
        choke_seen <= choke_cnt;
        nh = CHOKE_CYCLES;
      end
      if (nh > 0) begin
        rdy = 1'b0;
        nh--;
      end else if ((cycles / 600) % 4 == 0) begin
        rdy = 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        rdy = (r < 75);
        if (r >= 96) nh = $urandom_range(10, 30);
        else if (r >= 75) nh = $urandom_range(0, 3);
      end
      out_tready <= rdy;
      hold_left <= nh;
    end
  end

  task automatic report_token(input string why, input tok_t want, input tok_t got);
    if (errors < 10) begin
      $display("%0t %s: want kind %0d start %0d len %0d line %0d last %0b,",
               $realtime, why, want.kind, want.start, want.len, want.line, want.last);
      $display("  got kind %0d start %0d len %0d line %0d last %0b",
               got.kind, got.start, got.len, got.line, got.last);
    end
    errors++;
  endtask

  // token checker
  always @(posedge clk) begin : check_tokens
    tok_t got;
    tok_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.kind = out_tdata[4:0];
      got.start = out_tdata[20:5];
      got.len = out_tdata[36:21];
      got.line = out_tdata[52:37];
      got.last = out_tlast;
      n_checked++;
      if (token_q.size() == 0) begin
        want = '0;
        report_token("unexpected token", want, got);
      end else begin
        want = token_q.pop_front();
        if (got.kind !== want.kind || got.start !== want.start || got.len !== want.len ||
            got.line !== want.line || got.last !== want.last)
          report_token("token differs", want, got);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d tokens outstanding", cycles, token_q.size());
      $display("punctuation_string_lexer_unit: mismatch");
      $finish;
    end
  end

  initial begin : finish_run
    @(posedge rst_n);
    while (!(stim_done && token_q.size() == 0)) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("%0d items in %0d texts, %0d tokens checked, %0d mismatches", n_accepted,
             n_texts, n_checked, errors);
    $display("incl. all token kinds, open strings, comments, long sink stall, drain pause");
    if (errors == 0) begin
      $display("punctuation_string_lexer_unit: match");
    end else begin
      $display("punctuation_string_lexer_unit: mismatch");
    end
    $finish;
  end

endmodule
